>>> sv/tto_pkg.sv
// Shared types, command codes and constants for the triangle tangent orthogonalizer.
package tto_pkg;

    // Fixed-point constants of the tangent math
    localparam logic [15:0] OneQ14    = 16'd16384;
    localparam int          SqrtSteps = 32;
    localparam int          DivSteps  = 16;

    // One triangle corner
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } corner_t;

    // One orthogonalized tangent
    typedef struct packed {
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic               degenerate;
    } result_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD0,
        OP_LOAD1,
        OP_LOAD2,
        OP_MAGS,
        OP_DETA,
        OP_DETB,
        OP_DETC,
        OP_SHDV,
        OP_SHE,
        OP_TM1,
        OP_TA1,
        OP_TM2,
        OP_TA2,
        OP_TMAG,
        OP_SHT,
        OP_DM,
        OP_DA,
        OP_PM,
        OP_PA,
        OP_PMAG,
        OP_SHP,
        OP_SQ,
        OP_SQA,
        OP_SQI,
        OP_SQS,
        OP_DVI,
        OP_DVS,
        OP_DVE,
        OP_EMIT
    } op_t;

    // Command from controller to datapath
    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic       deg;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic dv_fit;
        logic e_fit;
        logic t_fit;
        logic p_fit;
        logic det_zero;
        logic sum_zero;
    } dp_stat_t;

endpackage

>>> sv/tto_datapath.sv
// Datapath: corner holding registers, shared multipliers, shift, square-root and divide steps.
module tto_datapath (
    input  logic              clk,
    input  tto_pkg::dp_cmd_t  cmd,
    input  tto_pkg::corner_t  corner,
    output tto_pkg::dp_stat_t stat,
    output tto_pkg::result_t  result
);

    // Held corners
    logic signed [31:0] hp0_reg [3];
    logic signed [31:0] hp1_reg [3];
    logic signed [31:0] ht0u_reg, ht0v_reg, ht1u_reg, ht1v_reg;
    logic signed [15:0] nrm_reg [3];

    // Edges and UV deltas
    logic signed [32:0] e_reg [6];
    logic        [31:0] e_mag_reg [6];
    logic signed [32:0] du1_reg, du2_reg;
    logic signed [32:0] dv_reg [2];
    logic        [31:0] dv_mag_reg [2];
    logic        [31:0] du1_mag_reg, du2_mag_reg;

    // Determinant sign
    logic [63:0] pa_reg, pb_reg;
    logic        n1_reg, n2_reg;
    logic        det_zero_reg, det_neg_reg;

    // Products
    logic signed [53:0] prod_reg;
    logic        [63:0] uprod_reg;

    // Tangent, projection, length
    logic signed [48:0] t_reg [3];
    logic        [47:0] t_mag_reg [3];
    logic signed [37:0] dot_reg;
    logic signed [53:0] p_reg [3];
    logic        [52:0] p_mag_reg [3];
    logic        [63:0] sum_reg;
    logic        [63:0] sq_v_reg, sq_r_reg, sq_bit_reg;

    // Divider
    logic [32:0]        rem_reg;
    logic [15:0]        nlo_reg;
    logic [15:0]        q_reg;
    logic signed [15:0] tan_reg [3];
    tto_pkg::result_t   out_reg;

    // Lane selection
    logic signed [32:0] e_lo, e_hi;
    logic signed [48:0] t_sel;
    logic signed [15:0] n_sel;
    logic        [52:0] pm_sel;
    logic               p_neg;
    logic signed [31:0] in_pos [3];

    always_comb
    begin
        e_lo   = e_reg[0];
        e_hi   = e_reg[3];
        t_sel  = t_reg[0];
        n_sel  = nrm_reg[0];
        pm_sel = p_mag_reg[0];
        p_neg  = p_reg[0][53];
        case (cmd.idx)
            2'd1:
            begin
                e_lo   = e_reg[1];
                e_hi   = e_reg[4];
                t_sel  = t_reg[1];
                n_sel  = nrm_reg[1];
                pm_sel = p_mag_reg[1];
                p_neg  = p_reg[1][53];
            end
            2'd2:
            begin
                e_lo   = e_reg[2];
                e_hi   = e_reg[5];
                t_sel  = t_reg[2];
                n_sel  = nrm_reg[2];
                pm_sel = p_mag_reg[2];
                p_neg  = p_reg[2][53];
            end
            default:
            begin
            end
        endcase
    end

    assign in_pos[0] = corner.pos_x;
    assign in_pos[1] = corner.pos_y;
    assign in_pos[2] = corner.pos_z;

    // Signed multiplier operands
    logic signed [15:0] mul_a;
    logic signed [37:0] mul_b;
    logic signed [53:0] mul_p;

    always_comb
    begin
        mul_a = n_sel;
        mul_b = dot_reg;
        case (cmd.op)
            tto_pkg::OP_TM1:
            begin
                mul_a = dv_reg[1][15:0];
                mul_b = {{6{e_lo[31]}}, e_lo[31:0]};
            end
            tto_pkg::OP_TM2:
            begin
                mul_a = dv_reg[0][15:0];
                mul_b = {{6{e_hi[31]}}, e_hi[31:0]};
            end
            tto_pkg::OP_DM:
            begin
                mul_a = n_sel;
                mul_b = {{17{t_sel[20]}}, t_sel[20:0]};
            end
            default:
            begin
                mul_a = n_sel;
                mul_b = dot_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Unsigned multiplier operands
    logic [31:0] ua, ub;
    logic [63:0] uprod;

    always_comb
    begin
        ua = pm_sel[31:0];
        ub = pm_sel[31:0];
        case (cmd.op)
            tto_pkg::OP_DETA:
            begin
                ua = du1_mag_reg;
                ub = dv_mag_reg[1];
            end
            tto_pkg::OP_DETB:
            begin
                ua = du2_mag_reg;
                ub = dv_mag_reg[0];
            end
            default:
            begin
                ua = pm_sel[31:0];
                ub = pm_sel[31:0];
            end
        endcase
    end

    assign uprod = ua * ub;

    // Determinant sign from the two stored products
    logic det_zero_next, det_neg_next;

    always_comb
    begin
        det_zero_next = 1'b0;
        det_neg_next  = 1'b0;
        if (n1_reg != n2_reg)
        begin
            det_neg_next = n1_reg;
        end
        else if (pa_reg == pb_reg)
        begin
            det_zero_next = 1'b1;
        end
        else if (!n1_reg)
        begin
            det_neg_next = (pa_reg < pb_reg);
        end
        else
        begin
            det_neg_next = (pa_reg > pb_reg);
        end
    end

    // Group fit checks
    assign stat.dv_fit = (dv_mag_reg[0][31:15] == '0) && (dv_mag_reg[1][31:15] == '0);
    assign stat.e_fit  = !(e_mag_reg[0][31] | e_mag_reg[1][31] | e_mag_reg[2][31]
                           | e_mag_reg[3][31] | e_mag_reg[4][31] | e_mag_reg[5][31]);
    assign stat.t_fit  = (t_mag_reg[0][47:20] == '0) && (t_mag_reg[1][47:20] == '0)
                         && (t_mag_reg[2][47:20] == '0);
    assign stat.p_fit  = (p_mag_reg[0][52:30] == '0) && (p_mag_reg[1][52:30] == '0)
                         && (p_mag_reg[2][52:30] == '0);
    assign stat.det_zero = det_zero_reg;
    assign stat.sum_zero = (sum_reg == '0);

    // Square-root step
    logic [63:0] sq_try;
    assign sq_try = sq_r_reg + sq_bit_reg;

    // Divider init and step
    logic [45:0] div_n;
    logic [33:0] rem2;
    logic [33:0] div_d;
    logic [15:0] q_clamp;

    assign div_n   = {pm_sel[30:0], 15'd0} + {15'd0, sq_r_reg[30:0]};
    assign rem2    = {rem_reg, nlo_reg[15]};
    assign div_d   = {2'b00, sq_r_reg[30:0], 1'b0};
    assign q_clamp = (q_reg > tto_pkg::OneQ14) ? tto_pkg::OneQ14 : q_reg;

    // Advance the datapath by the issued operation
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tto_pkg::OP_LOAD0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    hp0_reg[k] <= in_pos[k];
                end
                ht0u_reg   <= corner.tex_u;
                ht0v_reg   <= corner.tex_v;
                nrm_reg[0] <= corner.norm_x;
                nrm_reg[1] <= corner.norm_y;
                nrm_reg[2] <= corner.norm_z;
            end
            tto_pkg::OP_LOAD1:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    hp1_reg[k] <= in_pos[k];
                end
                ht1u_reg <= corner.tex_u;
                ht1v_reg <= corner.tex_v;
            end
            tto_pkg::OP_LOAD2:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e_reg[k]     <= 33'(hp1_reg[k]) - 33'(hp0_reg[k]);
                    e_reg[3 + k] <= 33'(in_pos[k]) - 33'(hp0_reg[k]);
                end
                du1_reg   <= 33'(ht1u_reg) - 33'(ht0u_reg);
                dv_reg[0] <= 33'(ht1v_reg) - 33'(ht0v_reg);
                du2_reg   <= 33'(corner.tex_u) - 33'(ht0u_reg);
                dv_reg[1] <= 33'(corner.tex_v) - 33'(ht0v_reg);
            end
            tto_pkg::OP_MAGS:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    e_mag_reg[k] <= e_reg[k][32] ? 32'(-e_reg[k]) : e_reg[k][31:0];
                end
                for (int k = 0; k < 2; k++)
                begin
                    dv_mag_reg[k] <= dv_reg[k][32] ? 32'(-dv_reg[k]) : dv_reg[k][31:0];
                end
                du1_mag_reg <= du1_reg[32] ? 32'(-du1_reg) : du1_reg[31:0];
                du2_mag_reg <= du2_reg[32] ? 32'(-du2_reg) : du2_reg[31:0];
            end
            tto_pkg::OP_DETA:
            begin
                pa_reg <= uprod;
                n1_reg <= (du1_mag_reg != '0) && (dv_mag_reg[1] != '0)
                          && (du1_reg[32] != dv_reg[1][32]);
            end
            tto_pkg::OP_DETB:
            begin
                pb_reg <= uprod;
                n2_reg <= (du2_mag_reg != '0) && (dv_mag_reg[0] != '0)
                          && (du2_reg[32] != dv_reg[0][32]);
            end
            tto_pkg::OP_DETC:
            begin
                det_zero_reg <= det_zero_next;
                det_neg_reg  <= det_neg_next;
            end
            tto_pkg::OP_SHDV:
            begin
                if (!stat.dv_fit)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        dv_reg[k]     <= dv_reg[k] >>> 1;
                        dv_mag_reg[k] <= dv_mag_reg[k] >> 1;
                    end
                end
            end
            tto_pkg::OP_SHE:
            begin
                if (!stat.e_fit)
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        e_reg[k]     <= e_reg[k] >>> 1;
                        e_mag_reg[k] <= e_mag_reg[k] >> 1;
                    end
                end
            end
            tto_pkg::OP_TM1, tto_pkg::OP_TM2, tto_pkg::OP_DM, tto_pkg::OP_PM:
            begin
                prod_reg <= mul_p;
            end
            tto_pkg::OP_TA1:
            begin
                t_reg[cmd.idx] <= prod_reg[48:0];
            end
            tto_pkg::OP_TA2:
            begin
                t_reg[cmd.idx] <= det_neg_reg ? (prod_reg[48:0] - t_sel)
                                              : (t_sel - prod_reg[48:0]);
            end
            tto_pkg::OP_TMAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    t_mag_reg[k] <= t_reg[k][48] ? 48'(-t_reg[k]) : t_reg[k][47:0];
                end
            end
            tto_pkg::OP_SHT:
            begin
                if (!stat.t_fit)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        t_reg[k]     <= t_reg[k] >>> 1;
                        t_mag_reg[k] <= t_mag_reg[k] >> 1;
                    end
                end
            end
            tto_pkg::OP_DA:
            begin
                dot_reg <= ((cmd.idx == 2'd0) ? 38'sd0 : dot_reg) + prod_reg[37:0];
            end
            tto_pkg::OP_PA:
            begin
                p_reg[cmd.idx] <= {{5{t_sel[20]}}, t_sel[20:0], 28'd0} - prod_reg;
            end
            tto_pkg::OP_PMAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p_mag_reg[k] <= p_reg[k][53] ? 53'(-p_reg[k]) : p_reg[k][52:0];
                end
            end
            tto_pkg::OP_SHP:
            begin
                if (!stat.p_fit)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        p_reg[k]     <= p_reg[k] >>> 1;
                        p_mag_reg[k] <= p_mag_reg[k] >> 1;
                    end
                end
                else
                begin
                    // take the magnitudes of the shifted values for length and divide
                    for (int k = 0; k < 3; k++)
                    begin
                        p_mag_reg[k] <= p_reg[k][53] ? 53'(-p_reg[k]) : p_reg[k][52:0];
                    end
                end
            end
            tto_pkg::OP_SQ:
            begin
                uprod_reg <= uprod;
            end
            tto_pkg::OP_SQA:
            begin
                sum_reg <= ((cmd.idx == 2'd0) ? 64'd0 : sum_reg) + uprod_reg;
            end
            tto_pkg::OP_SQI:
            begin
                sq_v_reg   <= sum_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            tto_pkg::OP_SQS:
            begin
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_reg <= sq_v_reg - sq_try;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            tto_pkg::OP_DVI:
            begin
                rem_reg <= {3'd0, div_n[45:16]};
                nlo_reg <= div_n[15:0];
                q_reg   <= '0;
            end
            tto_pkg::OP_DVS:
            begin
                if (rem2 >= div_d)
                begin
                    rem_reg <= 33'(rem2 - div_d);
                    q_reg   <= {q_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[32:0];
                    q_reg   <= {q_reg[14:0], 1'b0};
                end
                nlo_reg <= {nlo_reg[14:0], 1'b0};
            end
            tto_pkg::OP_DVE:
            begin
                tan_reg[cmd.idx] <= p_neg ? -$signed(q_clamp) : $signed(q_clamp);
            end
            tto_pkg::OP_EMIT:
            begin
                out_reg.tan_x      <= cmd.deg ? 16'sd0 : tan_reg[0];
                out_reg.tan_y      <= cmd.deg ? 16'sd0 : tan_reg[1];
                out_reg.tan_z      <= cmd.deg ? 16'sd0 : tan_reg[2];
                out_reg.degenerate <= cmd.deg;
            end
            default:
            begin
            end
        endcase
    end

    assign result = out_reg;

endmodule

>>> sv/tto_ctrl.sv
// Controller: corner counting, operation sequencing and result handshake.
module tto_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tto_pkg::dp_stat_t stat,
    output tto_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAGS,
        ST_DETA,
        ST_DETB,
        ST_DETC,
        ST_SHDV,
        ST_SHE,
        ST_TM1,
        ST_TA1,
        ST_TM2,
        ST_TA2,
        ST_TMAG,
        ST_SHT,
        ST_DM,
        ST_DA,
        ST_PM,
        ST_PA,
        ST_PMAG,
        ST_SHP,
        ST_SQ,
        ST_SQA,
        ST_SQI,
        ST_SQS,
        ST_DVI,
        ST_DVS,
        ST_DVE,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic [4:0] step_reg, step_next;
    logic       deg_reg, deg_next;
    logic       out_valid_reg, out_valid_next;

    // Decode next state and the datapath command
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        deg_next       = deg_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = tto_pkg::OP_IDLE;
        cmd.idx        = idx_reg;
        cmd.deg        = deg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cnt_reg)
                        2'd0:
                        begin
                            cmd.op   = tto_pkg::OP_LOAD0;
                            cnt_next = 2'd1;
                        end
                        2'd1:
                        begin
                            cmd.op   = tto_pkg::OP_LOAD1;
                            cnt_next = 2'd2;
                        end
                        default:
                        begin
                            cmd.op     = tto_pkg::OP_LOAD2;
                            cnt_next   = 2'd0;
                            idx_next   = 2'd0;
                            deg_next   = 1'b0;
                            state_next = ST_MAGS;
                        end
                    endcase
                end
            end
            ST_MAGS:
            begin
                cmd.op     = tto_pkg::OP_MAGS;
                state_next = ST_DETA;
            end
            ST_DETA:
            begin
                cmd.op     = tto_pkg::OP_DETA;
                state_next = ST_DETB;
            end
            ST_DETB:
            begin
                cmd.op     = tto_pkg::OP_DETB;
                state_next = ST_DETC;
            end
            ST_DETC:
            begin
                cmd.op     = tto_pkg::OP_DETC;
                state_next = ST_SHDV;
            end
            ST_SHDV:
            begin
                // drop straight to the result on a flat UV mapping
                if (stat.det_zero)
                begin
                    deg_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op = tto_pkg::OP_SHDV;
                    if (stat.dv_fit)
                    begin
                        state_next = ST_SHE;
                    end
                end
            end
            ST_SHE:
            begin
                cmd.op = tto_pkg::OP_SHE;
                if (stat.e_fit)
                begin
                    state_next = ST_TM1;
                end
            end
            ST_TM1:
            begin
                cmd.op     = tto_pkg::OP_TM1;
                state_next = ST_TA1;
            end
            ST_TA1:
            begin
                cmd.op     = tto_pkg::OP_TA1;
                state_next = ST_TM2;
            end
            ST_TM2:
            begin
                cmd.op     = tto_pkg::OP_TM2;
                state_next = ST_TA2;
            end
            ST_TA2:
            begin
                cmd.op = tto_pkg::OP_TA2;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_TMAG;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_TM1;
                end
            end
            ST_TMAG:
            begin
                cmd.op     = tto_pkg::OP_TMAG;
                state_next = ST_SHT;
            end
            ST_SHT:
            begin
                cmd.op = tto_pkg::OP_SHT;
                if (stat.t_fit)
                begin
                    state_next = ST_DM;
                end
            end
            ST_DM:
            begin
                cmd.op     = tto_pkg::OP_DM;
                state_next = ST_DA;
            end
            ST_DA:
            begin
                cmd.op = tto_pkg::OP_DA;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_PM;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DM;
                end
            end
            ST_PM:
            begin
                cmd.op     = tto_pkg::OP_PM;
                state_next = ST_PA;
            end
            ST_PA:
            begin
                cmd.op = tto_pkg::OP_PA;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_PMAG;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_PM;
                end
            end
            ST_PMAG:
            begin
                cmd.op     = tto_pkg::OP_PMAG;
                state_next = ST_SHP;
            end
            ST_SHP:
            begin
                cmd.op = tto_pkg::OP_SHP;
                if (stat.p_fit)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.op     = tto_pkg::OP_SQ;
                state_next = ST_SQA;
            end
            ST_SQA:
            begin
                cmd.op = tto_pkg::OP_SQA;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_SQI;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQ;
                end
            end
            ST_SQI:
            begin
                // drop to the result when the projection vanished
                cmd.op    = tto_pkg::OP_SQI;
                step_next = '0;
                if (stat.sum_zero)
                begin
                    deg_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SQS;
                end
            end
            ST_SQS:
            begin
                cmd.op    = tto_pkg::OP_SQS;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(tto_pkg::SqrtSteps - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DVI;
                end
            end
            ST_DVI:
            begin
                cmd.op     = tto_pkg::OP_DVI;
                step_next  = '0;
                state_next = ST_DVS;
            end
            ST_DVS:
            begin
                cmd.op    = tto_pkg::OP_DVS;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(tto_pkg::DivSteps - 1))
                begin
                    state_next = ST_DVE;
                end
            end
            ST_DVE:
            begin
                cmd.op = tto_pkg::OP_DVE;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DVI;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = tto_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            deg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            deg_reg       <= deg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> sv/triangle_tangent_orthogonalizer_core.sv
// Top level of the triangle tangent orthogonalizer: controller plus datapath.
// Corners arrive one request at a time; the first two are held and give no result.
// The third corner starts the tangent computation, which runs as a sequence over
// one shared signed multiplier, one 32x32 unsigned multiplier, a one-bit-per-cycle
// group shifter, a 32-step square root and a 16-step divider used once per component;
// its length depends on how far each value group must be shifted, and it ends early
// when the UV mapping is flat. No new corner is taken while it runs. A finished tangent
// waits in an output register; meanwhile the next triangle's corners are taken and its
// computation runs, holding before its own result until the output register is free.
// Degenerate triangles (flat UV mapping or zero projected tangent) give a zero tangent
// with the degenerate flag set.
module triangle_tangent_orthogonalizer_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tto_pkg::corner_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output tto_pkg::result_t out_data
);

    tto_pkg::dp_cmd_t  cmd;
    tto_pkg::dp_stat_t stat;

    tto_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tto_datapath u_datapath (
        .clk    (clk),
        .cmd    (cmd),
        .corner (in_data),
        .stat   (stat),
        .result (out_data)
    );

endmodule
